// ===== sv/lsrf_pkg.sv =====
// Package with the item types, register indexes and constants of the link supervisor.
package lsrf_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFLINE_MINUTES = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_ENABLE = 8'd3;

	localparam logic [TIME_W-1:0]  MS_PER_MINUTE          = 32'd60000;
	localparam logic [TIME_W-1:0]  RST_CHECK_INTERVAL     = 32'd10000;
	localparam logic [COUNT_W-1:0] RST_OFFLINE_MINUTES    = 16'd0;
	localparam logic [COUNT_W-1:0] RST_ATTEMPT_LIMIT      = 16'd5;
	localparam logic               RST_FALLBACK_ENABLE    = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              link_up;
		logic              station_mode;
	} poll_t;

	typedef struct packed {
		logic               came_up;
		logic               went_down;
		logic               reinit_link;
		logic               start_fallback;
		logic               restart_request;
		logic [COUNT_W-1:0] attempt_count;
	} event_t;

endpackage

// ===== sv/link_supervisor_retry_fallback_unit.sv =====
// Top level of the link supervisor with periodic re-init, fallback and restart.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   poll    | in_valid, in_ready, in_data          | in
//   event   | out_valid, out_ready, out_data       | out
//   config  | cfg_valid, cfg_ready, cfg_index/data | in
//
// Each poll item is taken into an input register, evaluated against the
// supervisor state combinationally and written to the output register, so the
// result is offered at the output once it has passed both registers, and a
// new item is taken every cycle unless the output stalls. A stalled output
// holds both stages; the input is ready whenever the input stage is empty or
// moving on. Reset restores the register defaults and clears all supervisor state.
module link_supervisor_retry_fallback_unit #(
	parameter logic [31:0] STABLE_MS = 32'd60000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lsrf_pkg::poll_t       in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lsrf_pkg::event_t      out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_index,
	input  logic [31:0]           cfg_data
);
	import lsrf_pkg::*;

	logic [TIME_W-1:0]  check_interval_q;
	logic [COUNT_W-1:0] offline_minutes_q;
	logic [TIME_W-1:0]  offline_limit_q;
	logic [COUNT_W-1:0] attempt_limit_q;
	logic               fallback_enable_q;

	logic               connected_q;
	logic [TIME_W-1:0]  last_check_q;
	logic [COUNT_W-1:0] attempts_q;
	logic [TIME_W-1:0]  stable_since_q;
	logic [TIME_W-1:0]  offline_since_q;

	logic               valid_s1;
	poll_t              item_s1;
	logic               out_valid_q;
	event_t             out_data_q;

	logic               out_free;
	logic               advance;

	logic               up;
	logic [TIME_W-1:0]  now;
	logic               came;
	logic               down;
	logic               reinit;
	logic               fallback;
	logic               restart_off;
	logic               restart_lim;
	logic               restart;
	logic [TIME_W-1:0]  stable_n;
	logic [TIME_W-1:0]  offline_n;
	logic [TIME_W-1:0]  last_n;
	logic [COUNT_W-1:0] attempts_n;
	logic [COUNT_W-1:0] attempts_inc;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign up  = item_s1.link_up;
	assign now = item_s1.now_ms;

	always_comb begin
		came        = 1'b0;
		down        = 1'b0;
		reinit      = 1'b0;
		fallback    = 1'b0;
		restart_off = 1'b0;
		restart_lim = 1'b0;
		stable_n    = stable_since_q;
		offline_n   = offline_since_q;
		last_n      = last_check_q;
		attempts_n  = attempts_q;

		if (up != connected_q) begin
			if (up) begin
				stable_n  = now;
				offline_n = '0;
				came      = 1'b1;
			end else begin
				stable_n  = '0;
				offline_n = now;
				last_n    = now - check_interval_q;
				down      = 1'b1;
			end
		end

		if (up && stable_n != '0 && (now - stable_n) >= STABLE_MS) begin
			attempts_n = '0;
			stable_n   = '0;
		end

		if (offline_minutes_q != '0 && offline_n != '0 && !up &&
				(now - offline_n) >= offline_limit_q) begin
			restart_off = 1'b1;
		end

		attempts_inc = attempts_n + COUNT_W'(1);
		if (!restart_off && !up && item_s1.station_mode &&
				(now - last_n) >= check_interval_q) begin
			last_n     = now;
			attempts_n = attempts_inc;
			reinit     = 1'b1;
			if (attempts_inc >= attempt_limit_q) begin
				if (fallback_enable_q) begin
					fallback   = 1'b1;
					attempts_n = '0;
				end else begin
					restart_lim = 1'b1;
				end
			end
		end

		restart = restart_off || restart_lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_interval_q  <= RST_CHECK_INTERVAL;
			offline_minutes_q <= RST_OFFLINE_MINUTES;
			offline_limit_q   <= '0;
			attempt_limit_q   <= RST_ATTEMPT_LIMIT;
			fallback_enable_q <= RST_FALLBACK_ENABLE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CHECK_INTERVAL: begin
					check_interval_q <= cfg_data;
				end
				REG_OFFLINE_MINUTES: begin
					offline_minutes_q <= cfg_data[COUNT_W-1:0];
					offline_limit_q   <= TIME_W'(cfg_data[COUNT_W-1:0] * MS_PER_MINUTE);
				end
				REG_ATTEMPT_LIMIT: begin
					attempt_limit_q <= cfg_data[COUNT_W-1:0];
				end
				REG_FALLBACK_ENABLE: begin
					fallback_enable_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_data_q.came_up         <= came;
			out_data_q.went_down       <= down;
			out_data_q.reinit_link     <= reinit;
			out_data_q.start_fallback  <= fallback;
			out_data_q.restart_request <= restart;
			out_data_q.attempt_count   <= restart ? '0 : attempts_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connected_q     <= 1'b0;
			last_check_q    <= '0;
			attempts_q      <= '0;
			stable_since_q  <= '0;
			offline_since_q <= '0;
		end else if (advance) begin
			if (restart) begin
				connected_q     <= 1'b0;
				last_check_q    <= '0;
				attempts_q      <= '0;
				stable_since_q  <= '0;
				offline_since_q <= '0;
			end else begin
				connected_q     <= up;
				last_check_q    <= last_n;
				attempts_q      <= attempts_n;
				stable_since_q  <= stable_n;
				offline_since_q <= offline_n;
			end
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the link supervisor: directed and random polls checked against a predictor.
module tb;
	import lsrf_pkg::*;

	localparam logic [TIME_W-1:0] STABLE_SPAN_MS = 32'd60000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 8'hFF;
	localparam int PHASES = 8;
	localparam int PHASE_POLLS = 190;

	class link_scoreboard;
		logic [TIME_W-1:0] interval_ms;
		logic [COUNT_W-1:0] offline_min;
		logic [COUNT_W-1:0] attempt_cap;
		logic fallback_on;
		logic connected;
		logic [TIME_W-1:0] last_check;
		logic [COUNT_W-1:0] attempts;
		logic [TIME_W-1:0] stable_since;
		logic [TIME_W-1:0] offline_since;
		event_t pending_events[$];
		int mismatches;

		function new();
			interval_ms = RST_CHECK_INTERVAL;
			offline_min = RST_OFFLINE_MINUTES;
			attempt_cap = RST_ATTEMPT_LIMIT;
			fallback_on = RST_FALLBACK_ENABLE;
			clear_link();
			mismatches = 0;
		endfunction

		function void clear_link();
			connected = 1'b0;
			last_check = '0;
			attempts = '0;
			stable_since = '0;
			offline_since = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_CHECK_INTERVAL: interval_ms = data;
			REG_OFFLINE_MINUTES: offline_min = data[COUNT_W-1:0];
			REG_ATTEMPT_LIMIT: attempt_cap = data[COUNT_W-1:0];
			REG_FALLBACK_ENABLE: fallback_on = data[0];
			default: ;
			endcase
		endfunction

		function void note_poll(poll_t p);
			event_t e;
			logic [TIME_W-1:0] off_ms;
			e = '0;
			if (p.link_up != connected) begin
				connected = p.link_up;
				if (p.link_up) begin
					stable_since = p.now_ms;
					offline_since = '0;
					e.came_up = 1'b1;
				end else begin
					stable_since = '0;
					offline_since = p.now_ms;
					last_check = p.now_ms - interval_ms;
					e.went_down = 1'b1;
				end
			end
			if (connected && stable_since != 0 && p.now_ms - stable_since >= STABLE_SPAN_MS) begin
				attempts = '0;
				stable_since = '0;
			end
			if (offline_min != 0 && offline_since != 0 && !connected) begin
				off_ms = {16'd0, offline_min} * MS_PER_MINUTE;
				if (p.now_ms - offline_since >= off_ms) begin
					e.restart_request = 1'b1;
					clear_link();
				end
			end
			if (!e.restart_request && !connected && p.station_mode &&
				p.now_ms - last_check >= interval_ms) begin
				last_check = p.now_ms;
				attempts = attempts + 1'b1;
				e.reinit_link = 1'b1;
				if (attempts >= attempt_cap) begin
					if (fallback_on) begin
						e.start_fallback = 1'b1;
						attempts = '0;
					end else begin
						e.restart_request = 1'b1;
						clear_link();
					end
				end
			end
			e.attempt_count = attempts;
			pending_events.push_back(e);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 100) begin
				$display("mismatch at %0t ns: %s", $realtime, what);
			end
		endtask

		task check_field(string name, int unsigned got, int unsigned want);
			if (got != want) begin
				report($sformatf("%s is %0d, expected %0d", name, got, want));
			end
		endtask

		task check_event(event_t got);
			event_t want;
			if (pending_events.size() == 0) begin
				report($sformatf("event %h arrived with no poll outstanding", got));
				return;
			end
			want = pending_events.pop_front();
			check_field("came_up", got.came_up, want.came_up);
			check_field("went_down", got.went_down, want.went_down);
			check_field("reinit_link", got.reinit_link, want.reinit_link);
			check_field("start_fallback", got.start_fallback, want.start_fallback);
			check_field("restart_request", got.restart_request, want.restart_request);
			check_field("attempt_count", got.attempt_count, want.attempt_count);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	poll_t in_data;
	logic out_valid;
	logic out_ready;
	event_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	link_scoreboard link_sb;
	logic [TIME_W-1:0] wall_ms;
	logic link_state;
	int src_calm;
	int sink_calm;

	link_supervisor_retry_fallback_unit #(
		.STABLE_MS(STABLE_SPAN_MS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap(inout int calm);
		int unsigned r;
		if (calm > 0) begin
			calm = calm - 1;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [TIME_W-1:0] time_step(logic [TIME_W-1:0] interval);
		int unsigned r;
		logic [TIME_W-1:0] reach;
		if (interval == 0 || interval > 20000) reach = 20000;
		else reach = interval + interval / 4 + 1;
		r = $urandom_range(0, 99);
		if (r < 40) return $urandom_range(0, 300);
		if (r < 75) return $urandom_range(0, reach);
		if (r < 92) return $urandom_range(0, 90000);
		if (r < 98) return $urandom_range(0, 5000000);
		return $urandom;
	endfunction

	task automatic send_poll(logic [TIME_W-1:0] now, logic up, logic sta);
		int gap;
		gap = pick_gap(src_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{now_ms: now, link_up: up, station_mode: sta};
		do @(posedge clk); while (!in_ready);
		link_sb.note_poll('{now_ms: now, link_up: up, station_mode: sta});
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		link_sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [TIME_W-1:0] interval, logic [COUNT_W-1:0] minutes,
		logic [COUNT_W-1:0] cap, logic fb);
		write_reg(REG_CHECK_INTERVAL, interval);
		write_reg(REG_OFFLINE_MINUTES, {16'd0, minutes});
		write_reg(REG_ATTEMPT_LIMIT, {16'd0, cap});
		write_reg(REG_FALLBACK_ENABLE, {31'd0, fb});
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (link_sb.pending_events.size() != 0) @(posedge clk);
	endtask

	task automatic run_phase(int polls);
		int unsigned r;
		logic sta;
		for (int i = 0; i < polls; i++) begin
			if ($urandom_range(0, 99) < 9) link_state = ~link_state;
			sta = ($urandom_range(0, 99) < 85);
			r = $urandom_range(0, 99);
			if (r == 0) wall_ms = '0;
			else wall_ms = wall_ms + time_step(link_sb.interval_ms);
			send_poll(wall_ms, link_state, sta);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			link_sb.check_event(out_data);
		end
	end

	initial begin
		int gap;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pick_gap(sink_calm);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#20000000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		link_sb = new();
		src_calm = 0;
		sink_calm = 0;
		wall_ms = '0;
		link_state = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default settings: periodic re-init, stable-link clear, fallback at the limit,
		// a stable window across the time wrap and a link loss at timestamp zero.
		send_poll(32'd0, 1'b0, 1'b1);
		send_poll(32'd10000, 1'b0, 1'b1);
		send_poll(32'd15000, 1'b0, 1'b1);
		send_poll(32'd20000, 1'b0, 1'b0);
		send_poll(32'd20001, 1'b1, 1'b0);
		send_poll(32'd80001, 1'b1, 1'b1);
		send_poll(32'd90000, 1'b0, 1'b1);
		send_poll(32'd100000, 1'b0, 1'b1);
		send_poll(32'd110000, 1'b0, 1'b1);
		send_poll(32'd120000, 1'b0, 1'b1);
		send_poll(32'd130000, 1'b0, 1'b1);
		send_poll(32'hFFFF_FFFF, 1'b1, 1'b1);
		send_poll(32'h0000_EA5F, 1'b1, 1'b1);
		send_poll(32'd0, 1'b0, 1'b1);
		settle();

		// Zero interval and zero limit without fallback, offline restart after one minute.
		configure(32'd0, 16'd1, 16'd0, 1'b0);
		write_reg(REG_SPARE_FIRST, 32'd123);
		write_reg(REG_SPARE_LAST, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_poll(32'd5, 1'b0, 1'b1);
		send_poll(32'd6, 1'b1, 1'b0);
		send_poll(32'd7, 1'b0, 1'b0);
		send_poll(32'd60007, 1'b0, 1'b0);
		send_poll(32'd60008, 1'b0, 1'b1);
		settle();

		// Largest settings: the longest interval and the longest offline time.
		configure(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_poll(32'd100, 1'b1, 1'b1);
		send_poll(32'd200, 1'b0, 1'b1);
		send_poll(32'd300, 1'b0, 1'b1);
		send_poll(32'd200 + 32'd3932100000, 1'b0, 1'b1);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: configure(32'd0, 16'd0, 16'd1, 1'b1);
			1: configure($urandom_range(50, 3000), 16'd1, 16'($urandom_range(1, 8)), 1'b0);
			2: configure($urandom_range(0, 500), 16'd0, 16'd0, 1'b1);
			3: configure(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
			4: configure($urandom, 16'($urandom), 16'($urandom), 1'b1);
			default: configure($urandom_range(0, 5000), 16'($urandom_range(0, 3)),
				16'($urandom_range(0, 10)), 1'($urandom_range(0, 1)));
			endcase
			run_phase(PHASE_POLLS);
			settle();
		end

		repeat (8) @(posedge clk);
		if (link_sb.mismatches == 0 && link_sb.pending_events.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ===== files.f =====
sv/lsrf_pkg.sv
sv/link_supervisor_retry_fallback_unit.sv
sim/tb.sv
